/* rtl/core/nmea_sentence_deframer_top_defines.svh */
// assertion macros for the nmea sentence deframer
// no dependencies; taken in by files that carry concurrent checks
`ifndef NMEA_SENTENCE_DEFRAMER_TOP_DEFINES_SVH
`define NMEA_SENTENCE_DEFRAMER_TOP_DEFINES_SVH

`ifndef ASSERT_OFF

// same-cycle implication, sampled on the rising clock edge
`define NSD_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("nsd check failed: same-cycle implication");

// next-cycle implication, sampled on the rising clock edge
`define NSD_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("nsd check failed: next-cycle implication");

`else

`define NSD_ASSERT_IMP(label, clk, rst, ante, cons)
`define NSD_ASSERT_NXT(label, clk, rst, ante, cons)

`endif

`endif

/* rtl/core/nsd_pkg.sv */
// shared types, codes and constants for the nmea sentence deframer
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package nsd_pkg;

   // frame characters
   localparam logic [7:0] CHAR_DOLLAR = 8'h24;
   localparam logic [7:0] CHAR_STAR   = 8'h2a;
   localparam logic [7:0] CHAR_A      = 8'h41;
   localparam logic [7:0] CHAR_ZERO   = 8'h30;

   // position of the byte checked for a gga sentence
   localparam logic [6:0] SIXTH_POS = 7'd5;

   // register widths and indexes
   localparam int unsigned CSR_DATA_W  = 7;
   localparam int unsigned CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_STAR_OFFSET  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MIN_FRAME_LENGTH = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_GGA_MIN_LENGTH   = 2'd2;

   // register reset values
   localparam logic [CSR_DATA_W-1:0] MAX_STAR_OFFSET_RST  = 7'd96;
   localparam logic [CSR_DATA_W-1:0] MIN_FRAME_LENGTH_RST = 7'd10;
   localparam logic [CSR_DATA_W-1:0] GGA_MIN_LENGTH_RST   = 7'd45;

   // frame status codes
   localparam logic [2:0] STATUS_OK        = 3'd0;
   localparam logic [2:0] STATUS_TOO_SHORT = 3'd1;
   localparam logic [2:0] STATUS_BAD_CKSUM = 3'd2;
   localparam logic [2:0] STATUS_SHORT_GGA = 3'd3;
   localparam logic [2:0] STATUS_TOO_LONG  = 3'd4;

   typedef enum logic [3:0] {
      PHASE_HUNT = 4'b0001,
      PHASE_BODY = 4'b0010,
      PHASE_CK1  = 4'b0100,
      PHASE_CK2  = 4'b1000
   } phase_type;

   // one nibble as an uppercase hex character
   function automatic logic [7:0] hex_upper(input logic [3:0] nib);
      logic [7:0] res;
      if (nib < 4'd10) begin
         res = CHAR_ZERO + {4'd0, nib};
      end else begin
         res = CHAR_A + {4'd0, nib - 4'd10};
      end
      return res;
   endfunction

endpackage

`default_nettype wire

/* rtl/core/nmea_sentence_deframer_top.sv */
// nmea 0183 sentence deframer: start hunt, byte indexing, xor checksum check
// depends on nsd_pkg and nmea_sentence_deframer_top_defines.svh
`timescale 1ns / 1ps
`default_nettype none
`include "nmea_sentence_deframer_top_defines.svh"

//  channel  direction  handshake              payload
//  req      in         req_valid / req_ready  req_rx_byte
//  rsp      out        rsp_valid / rsp_ready  out_byte, byte_index, is_last, frame_status,
//                                             computed_checksum, frame_length
//  csr      in         csr_wr_en (no wait)    csr_index, csr_wdata
//
//  one beat per cycle sustained while rsp_ready is high: a beat lands in the input register,
//  then the frame logic moves it into the result register
//  the input register takes a new beat while a result waits on rsp_ready, if it is empty
//  bytes dropped while hunting for '$' give no rsp beat
//  synchronous active-high reset returns to hunting with the register reset values

module nmea_sentence_deframer_top (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // input channel
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic [7:0]                        req_rx_byte,
   // result channel
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic [7:0]                             rsp_out_byte,
   output logic [6:0]                             rsp_byte_index,
   output logic                                   rsp_is_last,
   output logic [2:0]                             rsp_frame_status,
   output logic [7:0]                             rsp_computed_checksum,
   output logic [6:0]                             rsp_frame_length,
   // configuration writes
   input  wire logic                              csr_wr_en,
   input  wire logic [nsd_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [nsd_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   // configuration registers
   logic [nsd_pkg::CSR_DATA_W-1:0] max_star_offset_ff;
   logic [nsd_pkg::CSR_DATA_W-1:0] min_frame_length_ff;
   logic [nsd_pkg::CSR_DATA_W-1:0] gga_min_length_ff;

   // input register
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;

   // frame state
   nsd_pkg::phase_type phase_ff, phase_in;
   logic [6:0] byte_count_ff, byte_count_in;
   logic [7:0] running_xor_ff, running_xor_in;
   logic [7:0] first_check_ff, first_check_in;
   logic [7:0] sixth_byte_ff, sixth_byte_in;

   // result register
   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] out_byte_ff, out_byte_in;
   logic [6:0] byte_index_ff, byte_index_in;
   logic       is_last_ff, is_last_in;
   logic [2:0] status_ff, status_in;
   logic [7:0] cksum_ff, cksum_in;
   logic [6:0] length_ff, length_in;

   // frame logic
   logic       advance;
   logic       emit;
   logic       accept;
   logic [7:0] idx_plus1;
   logic [6:0] idx_sat;
   logic [7:0] sixth_eff;
   logic       cksum_ok;

   // the input beat moves on when the result register is free or being drained
   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign accept    = req_valid && req_ready;

   assign in_valid_in = accept || (in_valid_ff && !advance);

   // next position, true and saturated to the 7-bit field
   assign idx_plus1 = {1'b0, byte_count_ff} + 8'd1;
   assign idx_sat   = idx_plus1[7] ? 7'h7f : idx_plus1[6:0];

   // the byte at position 5 can itself be a check character
   assign sixth_eff = (byte_count_ff == nsd_pkg::SIXTH_POS) ? in_byte_ff : sixth_byte_ff;

   assign cksum_ok = (first_check_ff == nsd_pkg::hex_upper(running_xor_ff[7:4])) &&
                     (in_byte_ff == nsd_pkg::hex_upper(running_xor_ff[3:0]));

   always_comb begin
      phase_in       = phase_ff;
      byte_count_in  = byte_count_ff;
      running_xor_in = running_xor_ff;
      first_check_in = first_check_ff;
      sixth_byte_in  = sixth_byte_ff;
      emit           = 1'b0;
      out_byte_in    = in_byte_ff;
      byte_index_in  = byte_count_ff;
      is_last_in     = 1'b0;
      status_in      = nsd_pkg::STATUS_OK;
      cksum_in       = running_xor_ff;
      length_in      = idx_sat;

      case (phase_ff)
         nsd_pkg::PHASE_HUNT: begin
            if (in_byte_ff == nsd_pkg::CHAR_DOLLAR) begin
               emit           = 1'b1;
               phase_in       = nsd_pkg::PHASE_BODY;
               byte_count_in  = 7'd1;
               running_xor_in = 8'd0;
               first_check_in = 8'd0;
               sixth_byte_in  = 8'd0;
               byte_index_in  = 7'd0;
               cksum_in       = 8'd0;
               length_in      = 7'd1;
            end
         end
         nsd_pkg::PHASE_BODY: begin
            emit = 1'b1;
            if (byte_count_ff >= max_star_offset_ff) begin
               // no '*' in time: end marker, aborting byte dropped
               phase_in      = nsd_pkg::PHASE_HUNT;
               byte_count_in = 7'd0;
               out_byte_in   = 8'd0;
               is_last_in    = 1'b1;
               status_in     = nsd_pkg::STATUS_TOO_LONG;
               length_in     = byte_count_ff;
            end else begin
               sixth_byte_in = sixth_eff;
               if (in_byte_ff == nsd_pkg::CHAR_STAR) begin
                  phase_in = nsd_pkg::PHASE_CK1;
               end else begin
                  running_xor_in = running_xor_ff ^ in_byte_ff;
               end
               byte_count_in = idx_plus1[6:0];
               cksum_in      = running_xor_in;
               length_in     = idx_plus1[6:0];
            end
         end
         nsd_pkg::PHASE_CK1: begin
            emit           = 1'b1;
            sixth_byte_in  = sixth_eff;
            first_check_in = in_byte_ff;
            phase_in       = nsd_pkg::PHASE_CK2;
            byte_count_in  = idx_sat;
         end
         nsd_pkg::PHASE_CK2: begin
            emit          = 1'b1;
            sixth_byte_in = sixth_eff;
            phase_in      = nsd_pkg::PHASE_HUNT;
            byte_count_in = 7'd0;
            is_last_in    = 1'b1;
            // priority: too short, bad checksum, short gga
            if (idx_plus1 < {1'b0, min_frame_length_ff}) begin
               status_in = nsd_pkg::STATUS_TOO_SHORT;
            end else if (!cksum_ok) begin
               status_in = nsd_pkg::STATUS_BAD_CKSUM;
            end else if (sixth_eff == nsd_pkg::CHAR_A &&
                         idx_plus1 < {1'b0, gga_min_length_ff}) begin
               status_in = nsd_pkg::STATUS_SHORT_GGA;
            end
         end
         default: begin
            phase_in      = nsd_pkg::PHASE_HUNT;
            byte_count_in = 7'd0;
         end
      endcase
   end

   always_comb begin
      if (advance) begin
         rsp_valid_in = emit;
      end else begin
         rsp_valid_in = rsp_valid_ff && !rsp_ready;
      end
   end

   // control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         max_star_offset_ff  <= nsd_pkg::MAX_STAR_OFFSET_RST;
         min_frame_length_ff <= nsd_pkg::MIN_FRAME_LENGTH_RST;
         gga_min_length_ff   <= nsd_pkg::GGA_MIN_LENGTH_RST;
         in_valid_ff         <= 1'b0;
         rsp_valid_ff        <= 1'b0;
         phase_ff            <= nsd_pkg::PHASE_HUNT;
         byte_count_ff       <= 7'd0;
         running_xor_ff      <= 8'd0;
         first_check_ff      <= 8'd0;
         sixth_byte_ff       <= 8'd0;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               nsd_pkg::CSR_MAX_STAR_OFFSET:  max_star_offset_ff  <= csr_wdata;
               nsd_pkg::CSR_MIN_FRAME_LENGTH: min_frame_length_ff <= csr_wdata;
               nsd_pkg::CSR_GGA_MIN_LENGTH:   gga_min_length_ff   <= csr_wdata;
               default: ;
            endcase
         end
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            phase_ff       <= phase_in;
            byte_count_ff  <= byte_count_in;
            running_xor_ff <= running_xor_in;
            first_check_ff <= first_check_in;
            sixth_byte_ff  <= sixth_byte_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         in_byte_ff <= req_rx_byte;
      end
      if (advance && emit) begin
         out_byte_ff   <= out_byte_in;
         byte_index_ff <= byte_index_in;
         is_last_ff    <= is_last_in;
         status_ff     <= status_in;
         cksum_ff      <= cksum_in;
         length_ff     <= length_in;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_out_byte          = out_byte_ff;
   assign rsp_byte_index        = byte_index_ff;
   assign rsp_is_last           = is_last_ff;
   assign rsp_frame_status      = status_ff;
   assign rsp_computed_checksum = cksum_ff;
   assign rsp_frame_length      = length_ff;

   // checks
   `NSD_ASSERT_IMP(a_mid_status_ok, clock, reset, rsp_valid_ff && !is_last_ff, status_ff == nsd_pkg::STATUS_OK)
   `NSD_ASSERT_IMP(a_too_long_zero, clock, reset, rsp_valid_ff && status_ff == nsd_pkg::STATUS_TOO_LONG, out_byte_ff == 8'd0 && is_last_ff)
   `NSD_ASSERT_NXT(a_end_to_hunt, clock, reset, advance && emit && is_last_in, phase_ff == nsd_pkg::PHASE_HUNT && byte_count_ff == 7'd0)
   `NSD_ASSERT_NXT(a_start_index, clock, reset, advance && emit && phase_ff == nsd_pkg::PHASE_HUNT, rsp_valid_ff && byte_index_ff == 7'd0)

endmodule

`default_nettype wire

/* test/tb_top.sv */
// self-checking testbench for nmea_sentence_deframer_top: frames, checksums and status codes
// depends on nsd_pkg and the deframer rtl; a local frame predictor supplies expected beats
`timescale 1ns / 1ps

module tb_top;
   import nsd_pkg::*;

   // frame shapes the stimulus builder can produce
   localparam int FRAME_GOOD      = 0;
   localparam int FRAME_BAD_CK    = 1;
   localparam int FRAME_LOWER_HEX = 2;
   localparam int FRAME_NO_STAR   = 3;
   localparam int FRAME_CUT       = 4;

   // index with no register behind it, written to show it is ignored
   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED_INDEX = 2'd3;

   // quiet cycles before the watchdog gives up, and settle time after a drain
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int SETTLE_CYCLES  = 6;

   // results per settings block in the random part (8 blocks)
   localparam int BLOCK_RESULTS = 110;

   typedef struct packed {
      logic [7:0] data_b;
      logic [6:0] index;
      logic       last;
      logic [2:0] status;
      logic [7:0] cksum;
      logic [6:0] flen;
   } frame_beat_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic [7:0]             req_rx_byte = 8'd0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic [7:0]             rsp_out_byte;
   logic [6:0]             rsp_byte_index;
   logic                   rsp_is_last;
   logic [2:0]             rsp_frame_status;
   logic [7:0]             rsp_computed_checksum;
   logic [6:0]             rsp_frame_length;
   logic                   csr_wr_en = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   // predictor copy of the registers
   logic [6:0] star_limit;
   logic [6:0] min_len;
   logic [6:0] gga_len;

   // predictor copy of the frame state
   phase_type  phase;
   logic [6:0] pos_cnt;
   logic [7:0] xor_acc;
   logic [7:0] ck_hi;
   logic [7:0] pos5;

   frame_beat_type expected_beats[$];
   logic [7:0]     tx_bytes[$];

   int mismatch_count = 0;
   int block_results  = 0;
   int idle_pct       = 0;
   int stall_pct      = 0;
   int stall_cycles;

   always #5 clock = ~clock;

   nmea_sentence_deframer_top u_top (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_rx_byte           (req_rx_byte),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_out_byte          (rsp_out_byte),
      .rsp_byte_index        (rsp_byte_index),
      .rsp_is_last           (rsp_is_last),
      .rsp_frame_status      (rsp_frame_status),
      .rsp_computed_checksum (rsp_computed_checksum),
      .rsp_frame_length      (rsp_frame_length),
      .csr_wr_en             (csr_wr_en),
      .csr_index             (csr_index),
      .csr_wdata             (csr_wdata)
   );

   // uppercase hex digit for one nibble
   function automatic logic [7:0] hex_char(input logic [3:0] n);
      if (n < 4'd10) begin
         return CHAR_ZERO + 8'(n);
      end
      return CHAR_A - 8'd10 + 8'(n);
   endfunction

   // advance the frame predictor by one accepted byte; returns 1 when a beat is due
   function automatic bit frame_step(input logic [7:0] b, output frame_beat_type r);
      logic [6:0] idx;
      logic [7:0] len;
      bit         hit;
      bit         ck_ok;
      idx = pos_cnt;
      len = {1'b0, idx} + 8'd1;
      hit = 1'b1;
      r   = '0;
      if (phase == PHASE_HUNT) begin
         // only a start mark opens a frame, anything else is dropped
         if (b == CHAR_DOLLAR) begin
            pos_cnt  = 7'd1;
            xor_acc  = 8'd0;
            ck_hi    = 8'd0;
            pos5     = 8'd0;
            phase    = PHASE_BODY;
            r.data_b = b;
            r.flen   = 7'd1;
         end else begin
            hit = 1'b0;
         end
      end else if (phase == PHASE_BODY && idx >= star_limit) begin
         // no star by the span limit: end marker, the byte itself is lost
         r.index  = idx;
         r.last   = 1'b1;
         r.status = STATUS_TOO_LONG;
         r.cksum  = xor_acc;
         r.flen   = idx;
         phase    = PHASE_HUNT;
         pos_cnt  = 7'd0;
      end else begin
         if (idx == SIXTH_POS) begin
            pos5 = b;
         end
         r.data_b = b;
         r.index  = idx;
         r.flen   = (len > 8'd127) ? 7'd127 : len[6:0];
         case (phase)
            PHASE_BODY: begin
               if (b == CHAR_STAR) begin
                  phase = PHASE_CK1;
               end else begin
                  xor_acc = xor_acc ^ b;
               end
               pos_cnt = idx + 7'd1;
            end
            PHASE_CK1: begin
               ck_hi   = b;
               phase   = PHASE_CK2;
               pos_cnt = (idx == 7'd127) ? 7'd127 : idx + 7'd1;
            end
            default: begin
               ck_ok  = (ck_hi == hex_char(xor_acc[7:4])) && (b == hex_char(xor_acc[3:0]));
               r.last = 1'b1;
               if (len < {1'b0, min_len}) begin
                  r.status = STATUS_TOO_SHORT;
               end else if (!ck_ok) begin
                  r.status = STATUS_BAD_CKSUM;
               end else if (pos5 == CHAR_A && len < {1'b0, gga_len}) begin
                  r.status = STATUS_SHORT_GGA;
               end else begin
                  r.status = STATUS_OK;
               end
               phase   = PHASE_HUNT;
               pos_cnt = 7'd0;
            end
         endcase
         r.cksum = xor_acc;
      end
      return hit;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      if (mismatch_count < 50) begin
         $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $time);
      end
      mismatch_count++;
   endtask

   // one req beat: optional random gap, then hold valid until accepted
   task automatic send_byte(input logic [7:0] b);
      frame_beat_type r;
      if ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < idle_pct) begin
            @(posedge clock);
         end
      end
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      @(posedge clock);
      while (!req_ready) begin
         @(posedge clock);
      end
      if (frame_step(b, r)) begin
         expected_beats.push_back(r);
         block_results++;
      end
   endtask

   task automatic flush_tx();
      while (tx_bytes.size() != 0) begin
         send_byte(tx_bytes.pop_front());
      end
   endtask

   // stop sending, wait for every expected beat, then let the pipeline settle
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_beats.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // write all three registers plus the unused index
   task automatic apply_settings(input logic [6:0] lim, input logic [6:0] mfl,
                                 input logic [6:0] gml);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_MAX_STAR_OFFSET;
      csr_wdata <= lim;
      @(posedge clock);
      csr_index <= CSR_MIN_FRAME_LENGTH;
      csr_wdata <= mfl;
      @(posedge clock);
      csr_index <= CSR_GGA_MIN_LENGTH;
      csr_wdata <= gml;
      @(posedge clock);
      csr_index <= CSR_UNUSED_INDEX;
      csr_wdata <= 7'($urandom_range(127));
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(posedge clock);
      star_limit = lim;
      min_len    = mfl;
      gga_len    = gml;
   endtask

   // queue one sentence: '$', body, and unless cut or starless, '*' plus two check chars
   task automatic push_sentence(input int body_len, input int kind, input bit gga);
      logic [7:0] c;
      logic [7:0] acc;
      logic [7:0] hi;
      logic [7:0] lo;
      acc = 8'd0;
      tx_bytes.push_back(CHAR_DOLLAR);
      for (int i = 0; i < body_len; i++) begin
         c = ($urandom_range(99) < 20) ? 8'($urandom_range(255)) : 8'($urandom_range(32, 126));
         if (c == CHAR_STAR) begin
            c = CHAR_DOLLAR;   // start mark as plain data
         end
         if (gga && i == 4) begin
            c = CHAR_A;
         end
         tx_bytes.push_back(c);
         acc = acc ^ c;
      end
      if (kind != FRAME_NO_STAR && kind != FRAME_CUT) begin
         hi = hex_char(acc[7:4]);
         lo = hex_char(acc[3:0]);
         if (kind == FRAME_LOWER_HEX) begin
            if (hi >= CHAR_A) hi = hi | 8'h20;
            if (lo >= CHAR_A) lo = lo | 8'h20;
         end else if (kind == FRAME_BAD_CK) begin
            if ($urandom_range(1) == 1) begin
               hi = hi ^ (8'h01 << $urandom_range(7));
            end else begin
               lo = lo ^ (8'h01 << $urandom_range(7));
            end
         end
         tx_bytes.push_back(CHAR_STAR);
         tx_bytes.push_back(hi);
         tx_bytes.push_back(lo);
      end
   endtask

   // extremes of rx_byte under reset settings: dropped noise, then a too-short frame
   task automatic test_reset_defaults();
      tx_bytes = {8'h00, 8'hff, CHAR_DOLLAR, 8'hff, 8'h00, CHAR_STAR,
                  hex_char(4'hf), hex_char(4'hf)};
      flush_tx();
      drain();
   endtask

   // ok, bad checksum, short gga with '$' as data, then too long aborted by a '$'
   task automatic test_each_status();
      apply_settings(7'd16, 7'd4, 7'd127);
      tx_bytes = {CHAR_DOLLAR, CHAR_STAR, CHAR_ZERO, CHAR_ZERO};
      tx_bytes.push_back(CHAR_DOLLAR);
      tx_bytes.push_back(CHAR_STAR);
      tx_bytes.push_back(CHAR_ZERO);
      tx_bytes.push_back(CHAR_ZERO + 8'd1);
      flush_tx();
      // xor of "1$34A" is 0x53
      tx_bytes = {CHAR_DOLLAR, 8'h31, CHAR_DOLLAR, 8'h33, 8'h34, CHAR_A, CHAR_STAR,
                  hex_char(4'h5), hex_char(4'h3)};
      flush_tx();
      drain();
      apply_settings(7'd0, 7'd4, 7'd127);
      tx_bytes = {CHAR_DOLLAR, CHAR_DOLLAR, CHAR_STAR};
      flush_tx();
      drain();
   endtask

   // random sentences under two settings blocks for one idle and stall mode
   task automatic test_random_traffic(input int mode);
      int         sel;
      int         blen;
      int         kind;
      bit         gga;
      logic [6:0] lim;
      logic [6:0] mfl;
      logic [6:0] gml;
      case (mode)
         0: begin idle_pct = 0;  stall_pct = 0;  end
         1: begin idle_pct = 64; stall_pct = 0;  end
         2: begin idle_pct = 0;  stall_pct = 64; end
         default: begin idle_pct = 33; stall_pct = 33; end
      endcase
      for (int blk = mode * 2; blk < mode * 2 + 2; blk++) begin
         case (blk)
            0: begin lim = MAX_STAR_OFFSET_RST; mfl = MIN_FRAME_LENGTH_RST;
                     gml = GGA_MIN_LENGTH_RST; end
            1: begin lim = 7'd16;  mfl = 7'd4;   gml = 7'd0;   end
            2: begin lim = 7'd127; mfl = 7'd127; gml = 7'd127; end
            3: begin lim = 7'd16;  mfl = 7'd4;   gml = 7'd127; end
            default: begin
               lim = 7'($urandom_range(16, 127));
               mfl = 7'($urandom_range(4, 30));
               gml = 7'($urandom_range(0, 60));
            end
         endcase
         apply_settings(lim, mfl, gml);
         // longest frames: second check char at position 128, and star at the limit
         if (lim == 7'd127) begin
            push_sentence(125, FRAME_GOOD, 1'b0);
            push_sentence(126, FRAME_GOOD, 1'b0);
            flush_tx();
         end
         block_results = 0;
         while (block_results < BLOCK_RESULTS) begin
            sel = $urandom_range(99);
            if (sel < 8) begin
               // line noise between sentences
               repeat ($urandom_range(1, 6)) tx_bytes.push_back(8'($urandom_range(255)));
            end else if (sel < 14) begin
               push_sentence($urandom_range(0, 10), FRAME_CUT, 1'($urandom_range(1)));
            end else if (sel < 18) begin
               // star just inside or just at the span limit
               blen = int'(lim) - 2 + $urandom_range(1);
               push_sentence((blen < 0) ? 0 : blen, FRAME_GOOD, 1'b0);
            end else begin
               blen = ($urandom_range(99) < 70) ? $urandom_range(0, 12) : $urandom_range(0, 40);
               sel  = $urandom_range(99);
               gga  = ($urandom_range(99) < 30);
               if (sel < 65) begin
                  kind = FRAME_GOOD;
               end else if (sel < 85) begin
                  kind = FRAME_BAD_CK;
               end else if (sel < 93) begin
                  kind = FRAME_LOWER_HEX;
               end else begin
                  kind = FRAME_NO_STAR;
                  blen = int'(lim) + $urandom_range(0, 3);
               end
               push_sentence(blen, kind, gga);
            end
            flush_tx();
         end
         drain();
      end
   endtask

   // receiver back-pressure, redrawn every cycle
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= stall_pct);
   end

   // every rsp beat is matched against the oldest expected beat
   always @(posedge clock) begin : rsp_check
      frame_beat_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_beats.size() == 0) begin
            report_mismatch("beat with nothing expected, out_byte", rsp_out_byte, 0);
         end else begin
            want = expected_beats.pop_front();
            if (rsp_out_byte !== want.data_b)
               report_mismatch("out_byte", rsp_out_byte, want.data_b);
            if (rsp_byte_index !== want.index)
               report_mismatch("byte_index", rsp_byte_index, want.index);
            if (rsp_is_last !== want.last)
               report_mismatch("is_last", rsp_is_last, want.last);
            if (rsp_frame_status !== want.status)
               report_mismatch("frame_status", rsp_frame_status, want.status);
            if (rsp_computed_checksum !== want.cksum)
               report_mismatch("computed_checksum", rsp_computed_checksum, want.cksum);
            if (rsp_frame_length !== want.flen)
               report_mismatch("frame_length", rsp_frame_length, want.flen);
         end
      end
   end

   // ends the run when no beat moves on either channel for too long
   initial begin : watchdog
      stall_cycles = 0;
      while (stall_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            stall_cycles = 0;
         end else begin
            stall_cycles++;
         end
      end
      $display("RESULT: ERROR");
      $finish;
   end

   initial begin : main
      // predictor starts from the reset state
      star_limit = MAX_STAR_OFFSET_RST;
      min_len    = MIN_FRAME_LENGTH_RST;
      gga_len    = GGA_MIN_LENGTH_RST;
      phase      = PHASE_HUNT;
      pos_cnt    = 7'd0;
      xor_acc    = 8'd0;
      ck_hi      = 8'd0;
      pos5       = 8'd0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_defaults();
      test_each_status();
      for (int m = 0; m < 4; m++) begin
         test_random_traffic(m);
      end
      drain();

      if (mismatch_count == 0 && expected_beats.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
